FILE: rtl/gfe_pkg.sv
package gfe_pkg;

	// Widths fixed by the item and register fields.
	localparam int CFG_W    = 9;
	localparam int COORD_W  = 9;
	localparam int REMAIN_W = 17;
	// Wide enough for any active grid size and for a coordinate plus one.
	localparam int DIM_W    = 11;

	localparam logic [CFG_W-1:0] GRID_DIM_RESET = 9'd256;

	typedef enum logic [0:0] {
		REG_GRID_ROWS = 1'b0,
		REG_GRID_COLS = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		DIR_UP    = 2'd0,
		DIR_DOWN  = 2'd1,
		DIR_LEFT  = 2'd2,
		DIR_RIGHT = 2'd3
	} dir_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CHECK,
		ST_TEST,
		ST_POP,
		ST_FETCH,
		ST_NEIGH,
		ST_PROBE,
		ST_DONE
	} state_t;

	function automatic dir_t dir_next(input dir_t d);
		dir_t n;
		unique case (d)
			DIR_UP:    n = DIR_DOWN;
			DIR_DOWN:  n = DIR_LEFT;
			DIR_LEFT:  n = DIR_RIGHT;
			DIR_RIGHT: n = DIR_UP;
			default:   n = DIR_UP;
		endcase
		return n;
	endfunction

endpackage

FILE: rtl/gfe_ram.sv
module gfe_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: rtl/gfe_nbr.sv
module gfe_nbr #(
	parameter int RW = 8,
	parameter int CW = 8
) (
	input  logic [RW-1:0]              r,
	input  logic [CW-1:0]              c,
	input  gfe_pkg::dir_t              dir,
	input  logic [gfe_pkg::DIM_W-1:0]  rows,
	input  logic [gfe_pkg::DIM_W-1:0]  cols,
	output logic [RW-1:0]              nb_r,
	output logic [CW-1:0]              nb_c,
	output logic                       ok
);

	import gfe_pkg::*;

	// One neighbour per call; the bound check uses the active grid, not the array size.
	always_comb begin
		nb_r = r;
		nb_c = c;
		ok   = 1'b0;
		unique case (dir)
			DIR_UP: begin
				nb_r = r - RW'(1);
				ok   = (r != '0);
			end
			DIR_DOWN: begin
				nb_r = r + RW'(1);
				ok   = ((DIM_W'(r) + DIM_W'(1)) < rows);
			end
			DIR_LEFT: begin
				nb_c = c - CW'(1);
				ok   = (c != '0);
			end
			DIR_RIGHT: begin
				nb_c = c + CW'(1);
				ok   = ((DIM_W'(c) + DIM_W'(1)) < cols);
			end
			default: begin
				ok = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/grid_region_flood_erase_unit.sv
// Results: a load beat gives no result; an attack on a cell outside the grid or on a free cell
// returns the count without clearing anything, and one on an occupied cell returns it after
// clearing its region, with a probe of every in-grid neighbour of each cleared cell.
// Throughput: one item at a time; the map memory's single read port sets the pace of the walk.
// Reset: asynchronous, active low; afterwards the map is swept clear, one cell a cycle, over all
// MAX_ROWS * MAX_COLS cells (65536 by default) with in_ready low; register writes are taken.
module grid_region_flood_erase_unit #(
	parameter int MAX_ROWS = 256,
	parameter int MAX_COLS = 256
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_wen,
	input  gfe_pkg::reg_idx_t               cfg_index,
	input  logic [gfe_pkg::CFG_W-1:0]       cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic                            mode,
	input  logic [gfe_pkg::COORD_W-1:0]     row,
	input  logic [gfe_pkg::COORD_W-1:0]     col,
	input  logic                            land,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [gfe_pkg::REMAIN_W-1:0]    remaining
);

	import gfe_pkg::*;

	localparam int CELLS = MAX_ROWS * MAX_COLS;
	localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int IDXW  = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CNTW  = $clog2(CELLS + 1);
	localparam int QW    = RW + CW;

	localparam logic [DIM_W-1:0] ROWS_LIM = DIM_W'(MAX_ROWS);
	localparam logic [DIM_W-1:0] COLS_LIM = DIM_W'(MAX_COLS);

	// The cell index is row * MAX_COLS + column, as the map is laid out row by row.
	function automatic logic [IDXW-1:0] cell_addr(input logic [RW-1:0] r,
		input logic [CW-1:0] c);
		return IDXW'(IDXW'(r) * IDXW'(MAX_COLS)) + IDXW'(c);
	endfunction

	state_t state_q, state_d;

	logic [CFG_W-1:0]  grid_rows_q, grid_cols_q;
	logic [DIM_W-1:0]  rows_act, cols_act;
	logic [IDXW-1:0]   clr_q;
	logic              clr_last;
	logic [CNTW-1:0]   count_q;
	logic [CNTW-1:0]   head_q, tail_q;
	dir_t              dir_q;
	logic              dir_last;
	logic              out_valid_q;
	logic [REMAIN_W-1:0] remaining_q;

	// Item held for the duration of its work.
	logic              mode_q, land_q, inside_q;
	logic [RW-1:0]     cur_r_q, nb_r_q, nb_r, sel_r;
	logic [CW-1:0]     cur_c_q, nb_c_q, nb_c, sel_c;
	logic              nb_ok;
	logic              in_inside;

	// Memory ports.
	logic              map_we, map_wdata, map_rdata;
	logic [IDXW-1:0]   map_waddr, sel_addr;
	logic              q_we;
	logic [QW-1:0]     q_wdata, q_rdata;

	logic              accept, queue_empty, out_load;
	logic              count_inc, count_dec;

	// The active grid is the register value capped at the array size.
	assign rows_act = (DIM_W'(grid_rows_q) < ROWS_LIM) ? DIM_W'(grid_rows_q) : ROWS_LIM;
	assign cols_act = (DIM_W'(grid_cols_q) < COLS_LIM) ? DIM_W'(grid_cols_q) : COLS_LIM;

	assign in_inside = (row != '0) && (DIM_W'(row) <= rows_act) &&
		(col != '0) && (DIM_W'(col) <= cols_act);

	assign accept      = in_valid && in_ready;
	assign clr_last    = (clr_q == IDXW'(CELLS - 1));
	assign dir_last    = (dir_q == DIR_RIGHT);
	assign queue_empty = (head_q == tail_q);
	assign out_load    = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	assign out_valid = out_valid_q;
	assign remaining = remaining_q;

	gfe_nbr #(
		.RW(RW),
		.CW(CW)
	) u_nbr (
		.r    (cur_r_q),
		.c    (cur_c_q),
		.dir  (dir_q),
		.rows (rows_act),
		.cols (cols_act),
		.nb_r (nb_r),
		.nb_c (nb_c),
		.ok   (nb_ok)
	);

	// Occupancy map: one bit per cell, with a registered read used in the state after its address.
	gfe_ram #(
		.WIDTH(1),
		.DEPTH(CELLS)
	) u_map (
		.clk   (clk),
		.we    (map_we),
		.waddr (map_waddr),
		.wdata (map_wdata),
		.raddr (sel_addr),
		.rdata (map_rdata)
	);

	// Walk queue: cell coordinates in the order they were cleared.
	gfe_ram #(
		.WIDTH(QW),
		.DEPTH(CELLS)
	) u_queue (
		.clk   (clk),
		.we    (q_we),
		.waddr (tail_q[IDXW-1:0]),
		.wdata (q_wdata),
		.raddr (head_q[IDXW-1:0]),
		.rdata (q_rdata)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (inside_q) begin
					state_d = ST_TEST;
				end else if (mode_q) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_TEST: begin
				if (!mode_q) begin
					state_d = ST_IDLE;
				end else if (map_rdata) begin
					state_d = ST_POP;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_POP: begin
				state_d = queue_empty ? ST_DONE : ST_FETCH;
			end
			ST_FETCH: begin
				state_d = ST_NEIGH;
			end
			ST_NEIGH: begin
				if (nb_ok) begin
					state_d = ST_PROBE;
				end else if (dir_last) begin
					state_d = ST_POP;
				end
			end
			ST_PROBE: begin
				state_d = dir_last ? ST_POP : ST_NEIGH;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		map_we    = 1'b0;
		map_wdata = 1'b0;
		q_we      = 1'b0;
		q_wdata   = {cur_r_q, cur_c_q};
		sel_r     = cur_r_q;
		sel_c     = cur_c_q;
		unique case (state_q)
			ST_CLEAR: begin
				map_we = 1'b1;
			end
			ST_IDLE: begin
				in_ready = 1'b1;
			end
			ST_TEST: begin
				// A load writes only a changed bit; an attack clears and queues the start cell.
				if (mode_q) begin
					map_we = map_rdata;
					q_we   = map_rdata;
				end else begin
					map_we    = (map_rdata != land_q);
					map_wdata = land_q;
				end
			end
			ST_NEIGH: begin
				sel_r = nb_r;
				sel_c = nb_c;
			end
			ST_PROBE: begin
				sel_r   = nb_r_q;
				sel_c   = nb_c_q;
				map_we  = map_rdata;
				q_we    = map_rdata;
				q_wdata = {nb_r_q, nb_c_q};
			end
			ST_CHECK, ST_POP, ST_FETCH, ST_DONE: begin
				in_ready = 1'b0;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	assign sel_addr  = cell_addr(sel_r, sel_c);
	assign map_waddr = (state_q == ST_CLEAR) ? clr_q : sel_addr;

	assign count_inc = (state_q == ST_TEST) && !mode_q && map_we && land_q;
	assign count_dec = (state_q != ST_CLEAR) && map_we && !map_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			grid_rows_q <= GRID_DIM_RESET;
			grid_cols_q <= GRID_DIM_RESET;
			count_q     <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			dir_q       <= DIR_UP;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IDXW'(1);
			end

			if (cfg_wen) begin
				unique case (cfg_index)
					REG_GRID_ROWS: grid_rows_q <= cfg_data;
					REG_GRID_COLS: grid_cols_q <= cfg_data;
					default:       grid_rows_q <= grid_rows_q;
				endcase
			end

			if (count_inc) begin
				count_q <= count_q + CNTW'(1);
			end else if (count_dec && (count_q != '0)) begin
				count_q <= count_q - CNTW'(1);
			end

			if (accept) begin
				head_q <= '0;
				tail_q <= '0;
			end else begin
				if (q_we) begin
					tail_q <= tail_q + CNTW'(1);
				end
				if ((state_q == ST_POP) && !queue_empty) begin
					head_q <= head_q + CNTW'(1);
				end
			end

			if (state_q == ST_FETCH) begin
				dir_q <= DIR_UP;
			end else if ((state_q == ST_PROBE) || ((state_q == ST_NEIGH) && !nb_ok)) begin
				dir_q <= dir_next(dir_q);
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= mode;
			land_q   <= land;
			inside_q <= in_inside;
			cur_r_q  <= RW'(row - COORD_W'(1));
			cur_c_q  <= CW'(col - COORD_W'(1));
		end else if (state_q == ST_FETCH) begin
			cur_r_q <= q_rdata[QW-1:CW];
			cur_c_q <= q_rdata[CW-1:0];
		end
		if (state_q == ST_NEIGH) begin
			nb_r_q <= nb_r;
			nb_c_q <= nb_c;
		end
		if (out_load) begin
			remaining_q <= REMAIN_W'(count_q);
		end
	end

endmodule

FILE: rtl/gfe_checker.sv
module gfe_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [gfe_pkg::REMAIN_W-1:0]  remaining
);

	// A waiting result beat keeps its value until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(remaining))
		else $error("result beat changed while stalled");

	// A result beat leaves only when taken.
	a_out_leave: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(out_valid) |-> $past(out_ready))
		else $error("result beat dropped without being taken");

	// Each accepted item keeps the block busy for at least the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on two consecutive cycles");

	// A new result is only produced at the end of an item's work.
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while the block was idle");

endmodule

bind grid_region_flood_erase_unit gfe_checker u_gfe_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.remaining (remaining)
);

FILE: test/tb_top.sv
module tb_top;

	timeunit 1ns;
	timeprecision 1ps;

	import gfe_pkg::*;

	// Geometry of the block under test; the map is indexed row * GRID_MAX_COLS + col.
	localparam int GRID_MAX_ROWS = 256;
	localparam int GRID_MAX_COLS = 256;
	localparam int GRID_CELLS    = GRID_MAX_ROWS * GRID_MAX_COLS;

	// Opcodes carried on the mode field.
	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_ATTACK = 1'b1;

	// A load and an attack that clears nothing both finish well within this wait after their
	// beat, so it is ample before touching a register.
	localparam int SETTLE_CYCLES = 12;
	// Roughly how many counted input beats the random part sends.
	localparam int RANDOM_BEATS  = 420;
	// Watchdog limit for the whole run, clearing pass included.
	localparam int CYCLE_LIMIT   = 1000000;

	typedef enum logic [1:0] {
		STEP_LOAD,
		STEP_ATTACK,
		STEP_REG
	} step_kind_t;

	// One row of the opening script. For a register row, sel and value are used; for a
	// beat, row, col and land. Where known is set, want is the remaining count that the
	// attack must return, worked out by hand.
	typedef struct packed {
		step_kind_t      kind;
		reg_idx_t        sel;
		logic [8:0]      value;
		logic [8:0]      row;
		logic [8:0]      col;
		logic            land;
		bit              known;
		logic [16:0]     want;
	} script_step_t;

	// Opening script. It starts on the full 256 x 256 grid with an empty map, so every
	// count below can be followed by eye.
	localparam script_step_t OPENING [25] = '{
		// Attack on an empty map right after reset.
		'{STEP_ATTACK, REG_GRID_ROWS, 9'd0,   9'd1,   9'd1,   1'b0, 1'b1, 17'd0},
		// A load, then the same load again, which must leave the count alone.
		'{STEP_LOAD,   REG_GRID_ROWS, 9'd0,   9'd1,   9'd1,   1'b1, 1'b0, 17'd0},
		'{STEP_LOAD,   REG_GRID_ROWS, 9'd0,   9'd1,   9'd1,   1'b1, 1'b0, 17'd0},
		// A small L-shaped region in the far corner, plus a lone cell in the top right.
		'{STEP_LOAD,   REG_GRID_ROWS, 9'd0,   9'd256, 9'd256, 1'b1, 1'b0, 17'd0},
		'{STEP_LOAD,   REG_GRID_ROWS, 9'd0,   9'd256, 9'd255, 1'b1, 1'b0, 17'd0},
		'{STEP_LOAD,   REG_GRID_ROWS, 9'd0,   9'd255, 9'd256, 1'b1, 1'b0, 17'd0},
		'{STEP_LOAD,   REG_GRID_ROWS, 9'd0,   9'd1,   9'd256, 1'b1, 1'b0, 17'd0},
		// Loads off the grid are dropped.
		'{STEP_LOAD,   REG_GRID_ROWS, 9'd0,   9'd0,   9'd5,   1'b1, 1'b0, 17'd0},
		'{STEP_LOAD,   REG_GRID_ROWS, 9'd0,   9'd511, 9'd511, 1'b1, 1'b0, 17'd0},
		// Attacks off the grid and on a free cell clear nothing.
		'{STEP_ATTACK, REG_GRID_ROWS, 9'd0,   9'd0,   9'd0,   1'b1, 1'b1, 17'd5},
		'{STEP_ATTACK, REG_GRID_ROWS, 9'd0,   9'd2,   9'd2,   1'b0, 1'b1, 17'd5},
		// The corner region goes; its neighbours beyond the edge must be skipped.
		'{STEP_ATTACK, REG_GRID_ROWS, 9'd0,   9'd256, 9'd256, 1'b1, 1'b1, 17'd2},
		'{STEP_LOAD,   REG_GRID_ROWS, 9'd0,   9'd1,   9'd2,   1'b1, 1'b0, 17'd0},
		'{STEP_LOAD,   REG_GRID_ROWS, 9'd0,   9'd1,   9'd256, 1'b0, 1'b0, 17'd0},
		'{STEP_LOAD,   REG_GRID_ROWS, 9'd0,   9'd200, 9'd200, 1'b1, 1'b0, 17'd0},
		// Shrink to 4 x 4: the cell at 200,200 still counts but cannot be reached.
		'{STEP_REG,    REG_GRID_ROWS, 9'd4,   9'd0,   9'd0,   1'b0, 1'b0, 17'd0},
		'{STEP_REG,    REG_GRID_COLS, 9'd4,   9'd0,   9'd0,   1'b0, 1'b0, 17'd0},
		'{STEP_ATTACK, REG_GRID_ROWS, 9'd0,   9'd200, 9'd200, 1'b0, 1'b1, 17'd3},
		'{STEP_ATTACK, REG_GRID_ROWS, 9'd0,   9'd1,   9'd2,   1'b0, 1'b1, 17'd1},
		// A zero row count leaves no grid at all.
		'{STEP_REG,    REG_GRID_ROWS, 9'd0,   9'd0,   9'd0,   1'b0, 1'b0, 17'd0},
		'{STEP_LOAD,   REG_GRID_ROWS, 9'd0,   9'd1,   9'd1,   1'b1, 1'b0, 17'd0},
		'{STEP_ATTACK, REG_GRID_ROWS, 9'd0,   9'd1,   9'd1,   1'b1, 1'b1, 17'd1},
		// Back to the full grid, where the stranded cell can be reached again.
		'{STEP_REG,    REG_GRID_ROWS, 9'd256, 9'd0,   9'd0,   1'b0, 1'b0, 17'd0},
		'{STEP_REG,    REG_GRID_COLS, 9'd256, 9'd0,   9'd0,   1'b0, 1'b0, 17'd0},
		'{STEP_ATTACK, REG_GRID_ROWS, 9'd0,   9'd200, 9'd200, 1'b0, 1'b1, 17'd0}
	};

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wen;
	reg_idx_t              cfg_index;
	logic [CFG_W-1:0]      cfg_data;
	logic                  in_valid;
	logic                  in_ready;
	logic                  mode;
	logic [COORD_W-1:0]    row;
	logic [COORD_W-1:0]    col;
	logic                  land;
	logic                  out_valid;
	logic                  out_ready;
	logic [REMAIN_W-1:0]   remaining;

	grid_region_flood_erase_unit #(
		.MAX_ROWS(GRID_MAX_ROWS),
		.MAX_COLS(GRID_MAX_COLS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.row(row),
		.col(col),
		.land(land),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.remaining(remaining)
	);

	// Shadow of the block's state: the occupancy map, the count and both registers.
	bit          occ_map [GRID_CELLS];
	int unsigned occ_count;
	logic [8:0]  shadow_rows;
	logic [8:0]  shadow_cols;

	// Remaining counts that attacks already accepted are still owed, oldest first.
	logic [REMAIN_W-1:0] expected_remaining [$];

	int  mismatches;
	int  beats_sent;
	int  cycle_count;
	// When set, neither side inserts idle cycles, so the block is run back to back.
	bit  calm;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost result ends the run here.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	// Mostly short idles, now and then a long one.
	function automatic int pick_idle();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(10, 40);
		return $urandom_range(1, 3);
	endfunction

	// Applies one accepted beat to the shadow state. Returns 1 when the beat is an attack,
	// with the count that the block must then report in rem.
	function automatic bit predict_grid_beat(input logic m, input logic [8:0] r,
			input logic [8:0] c, input logic l, output logic [REMAIN_W-1:0] rem);
		int unsigned nr, nc, idx, cur, cr, cc, nb;
		bit in_grid, reach;
		dir_t d;
		int unsigned walk [$];

		// Register values above the physical size are clipped to it.
		nr = (shadow_rows < GRID_MAX_ROWS) ? shadow_rows : GRID_MAX_ROWS;
		nc = (shadow_cols < GRID_MAX_COLS) ? shadow_cols : GRID_MAX_COLS;
		rem = '0;
		in_grid = (r >= 1) && (r <= nr) && (c >= 1) && (c <= nc);
		idx = in_grid ? (int'(r) - 1) * GRID_MAX_COLS + int'(c) - 1 : 0;

		if (m == MODE_LOAD) begin
			if (in_grid && occ_map[idx] != l) begin
				occ_map[idx] = l;
				if (l)
					occ_count++;
				else if (occ_count > 0)
					occ_count--;
			end
			return 1'b0;
		end

		// Breadth-first erase. A cell is cleared as it is queued, so it is never queued
		// twice; the walk is bounded by the grid in use, not by the physical map.
		if (in_grid && occ_map[idx]) begin
			occ_map[idx] = 1'b0;
			occ_count--;
			walk.push_back(idx);
			while (walk.size() > 0) begin
				cur = walk.pop_front();
				cr = cur / GRID_MAX_COLS;
				cc = cur % GRID_MAX_COLS;
				for (int k = 0; k < 4; k++) begin
					d = dir_t'(k);
					case (d)
						DIR_UP: begin
							reach = (cr > 0);
							nb = cur - GRID_MAX_COLS;
						end
						DIR_DOWN: begin
							reach = (cr + 1 < nr);
							nb = cur + GRID_MAX_COLS;
						end
						DIR_LEFT: begin
							reach = (cc > 0);
							nb = cur - 1;
						end
						default: begin
							reach = (cc + 1 < nc);
							nb = cur + 1;
						end
					endcase
					if (reach && occ_map[nb]) begin
						occ_map[nb] = 1'b0;
						if (occ_count > 0)
							occ_count--;
						walk.push_back(nb);
					end
				end
			end
		end
		rem = REMAIN_W'(occ_count);
		return 1'b1;
	endfunction

	// Drives one beat and holds it until it is taken. Valid is left high on return, so a
	// following beat with no idle goes out on the very next edge; whoever comes next
	// lowers valid when it wants a gap.
	task automatic send_beat(input logic m, input logic [8:0] r, input logic [8:0] c,
			input logic l, input bit known, input logic [REMAIN_W-1:0] want);
		int gap;
		bit has_result;
		logic [REMAIN_W-1:0] rem;

		gap = (calm || $urandom_range(0, 2) != 0) ? 0 : pick_idle();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= m;
		row <= r;
		col <= c;
		land <= l;
		do
			@(posedge clk);
		while (!in_ready);
		has_result = predict_grid_beat(m, r, c, l, rem);
		if (has_result)
			expected_remaining.push_back(known ? want : rem);
	endtask

	// Registers are only touched with the block idle: nothing owed, and long enough
	// since the last beat for a trailing load to have finished.
	task automatic write_reg(input reg_idx_t sel, input logic [8:0] value);
		in_valid <= 1'b0;
		while (expected_remaining.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= sel;
		cfg_data <= value;
		@(posedge clk);
		cfg_wen <= 1'b0;
		if (sel == REG_GRID_ROWS)
			shadow_rows = value;
		else
			shadow_cols = value;
	endtask

	// Any opcode at any coordinate, including ones well off the grid. Not counted.
	task automatic send_noise();
		send_beat(1'($urandom_range(0, 1)), 9'($urandom_range(0, 511)),
			9'($urandom_range(0, 511)), 1'($urandom_range(0, 1)), 1'b0, '0);
	endtask

	// One random phase: pick a grid, paint a window of it at random density, then attack
	// cells inside the window. Stray beats are sprinkled in between. The map is never
	// cleared between phases, so earlier shapes and stranded cells keep counting.
	task automatic run_random_phase();
		int nr, nc, wr, wc, r0, c0, density;
		logic [8:0] rows_val, cols_val;

		case ($urandom_range(0, 9))
			0: begin
				rows_val = 9'd1;
				cols_val = 9'($urandom_range(1, 12));
			end
			1: begin
				rows_val = 9'($urandom_range(1, 12));
				cols_val = 9'd1;
			end
			2: begin
				rows_val = 9'd256;
				cols_val = 9'd256;
			end
			3: begin
				rows_val = 9'($urandom_range(1, 256));
				cols_val = 9'($urandom_range(1, 256));
			end
			4: begin
				rows_val = 9'd256;
				cols_val = 9'($urandom_range(1, 8));
			end
			default: begin
				rows_val = 9'($urandom_range(2, 8));
				cols_val = 9'($urandom_range(2, 8));
			end
		endcase
		calm = ($urandom_range(0, 4) == 0);
		write_reg(REG_GRID_ROWS, rows_val);
		write_reg(REG_GRID_COLS, cols_val);

		nr = rows_val;
		nc = cols_val;
		wr = $urandom_range(1, (nr < 8) ? nr : 8);
		wc = $urandom_range(1, (nc < 8) ? nc : 8);
		// Favour windows that touch the edges of the grid, where the walk must stop.
		case ($urandom_range(0, 2))
			0: r0 = 1;
			1: r0 = nr - wr + 1;
			default: r0 = $urandom_range(1, nr - wr + 1);
		endcase
		case ($urandom_range(0, 2))
			0: c0 = 1;
			1: c0 = nc - wc + 1;
			default: c0 = $urandom_range(1, nc - wc + 1);
		endcase
		density = $urandom_range(35, 85);

		for (int i = 0; i < wr; i++) begin
			for (int j = 0; j < wc; j++) begin
				if ($urandom_range(0, 7) == 0)
					send_noise();
				if ($urandom_range(1, 100) <= density) begin
					send_beat(MODE_LOAD, 9'(r0 + i), 9'(c0 + j), 1'b1, 1'b0, '0);
					beats_sent++;
				end else if ($urandom_range(0, 3) == 0) begin
					send_beat(MODE_LOAD, 9'(r0 + i), 9'(c0 + j), 1'b0, 1'b0, '0);
					beats_sent++;
				end
			end
		end

		repeat ($urandom_range(2, 6)) begin
			if ($urandom_range(0, 7) == 0)
				send_noise();
			send_beat(MODE_ATTACK, 9'(r0 + $urandom_range(0, wr - 1)),
				9'(c0 + $urandom_range(0, wc - 1)), 1'($urandom_range(0, 1)), 1'b0, '0);
			beats_sent++;
		end
	endtask

	// Result side: check every beat that is taken, then decide the next cycle's ready.
	// Values are sampled straight after the edge, before the block's own updates land.
	initial begin
		logic [REMAIN_W-1:0] want;
		int hold_left;

		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				if (expected_remaining.size() == 0) begin
					report_mismatch($sformatf("unexpected result, remaining %0d", remaining));
				end else begin
					want = expected_remaining.pop_front();
					if (remaining !== want)
						report_mismatch($sformatf("remaining %0d, wanted %0d", remaining, want));
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (!calm && $urandom_range(0, 3) == 0)
					hold_left = pick_idle();
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		script_step_t step;

		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = REG_GRID_ROWS;
		cfg_data = '0;
		in_valid = 1'b0;
		mode = MODE_LOAD;
		row = '0;
		col = '0;
		land = 1'b0;
		occ_count = 0;
		shadow_rows = GRID_DIM_RESET;
		shadow_cols = GRID_DIM_RESET;
		mismatches = 0;
		beats_sent = 0;
		calm = 1'b0;

		// One reset at the start. The block then sweeps its map with in_ready low, and the
		// first beat simply waits for that to finish.
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < $size(OPENING); i++) begin
			step = OPENING[i];
			case (step.kind)
				STEP_REG:
					write_reg(step.sel, step.value);
				STEP_LOAD:
					send_beat(MODE_LOAD, step.row, step.col, step.land, 1'b0, '0);
				default:
					send_beat(MODE_ATTACK, step.row, step.col, step.land, step.known, step.want);
			endcase
		end

		while (beats_sent < RANDOM_BEATS)
			run_random_phase();

		// Drain: wait for every owed result, then give a trailing load time to finish.
		in_valid <= 1'b0;
		calm = 1'b0;
		while (expected_remaining.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

FILE: files.f
rtl/gfe_pkg.sv
rtl/gfe_ram.sv
rtl/gfe_nbr.sv
rtl/grid_region_flood_erase_unit.sv
rtl/gfe_checker.sv
test/tb_top.sv
